>>> hw/rtl/skl_pkg.sv
`default_nettype none

package skl_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_SORTED = 3'd0,
        OP_FRONT  = 3'd1,
        OP_POP    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_SEARCH = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMP_EQ = 2'd0,
        CMP_GE = 2'd1,
        CMP_GT = 2'd2
    } t_cmp;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_LEFT  = 2'd2,
        CELL_RIGHT = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic     cmp_en;
        logic     occupied;
        t_cmp     mode;
        t_cell_op op;
    } t_cell_ctl;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] key;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] position;
        logic [4:0] entry_count;
    } t_out_item;

endpackage

`default_nettype wire

>>> hw/rtl/skl_cell.sv
`default_nettype none

module skl_cell (
    input  wire                          i_clk,
    input  skl_pkg::t_cell_ctl           i_ctl,
    input  wire  [skl_pkg::KEY_BITS-1:0] i_key,
    input  wire  [skl_pkg::KEY_BITS-1:0] i_left,
    input  wire  [skl_pkg::KEY_BITS-1:0] i_right,
    output logic [skl_pkg::KEY_BITS-1:0] o_key,
    output logic                         o_flag
);
    import skl_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic                r_flag;
    logic                n_flag;
    logic                w_hit;

    always_comb begin
        case (i_ctl.mode)
            CMP_EQ:  w_hit = (r_key == i_key);
            CMP_GE:  w_hit = (r_key >= i_key);
            CMP_GT:  w_hit = (r_key > i_key);
            default: w_hit = 1'b0;
        endcase
        n_flag = i_ctl.cmp_en ? (i_ctl.occupied & w_hit) : r_flag;
    end

    always_comb begin
        unique case (i_ctl.op)
            CELL_HOLD:  n_key = r_key;
            CELL_LOAD:  n_key = i_key;
            CELL_LEFT:  n_key = i_left;
            CELL_RIGHT: n_key = i_right;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_flag <= n_flag;
    end

    assign o_key  = r_key;
    assign o_flag = r_flag;

endmodule

`default_nettype wire

>>> hw/rtl/sorted_key_list.sv
// Sorted key list: a row of CAPACITY slot cells, slot 0 the head, keeping keys in order.
// Each transaction on the input channel carries one operation (sorted insert, front insert,
// remove head, remove key, search) and yields exactly one result transaction with status,
// slot position and the number of keys held afterwards. An operation is accepted in S_IDLE;
// in S_CMP every cell compares its key with the operand at once and registers its hit; in
// S_APPLY the first hit is priority-encoded and the cells shift left or right by one slot
// to open or close the gap. A new operation is accepted while a finished result still
// waits on the output register; S_APPLY stalls only while that register is full and not taken.
// Reset clears count, state and result valid but not slot contents; unoccupied slots never hit.
`default_nettype none

module sorted_key_list (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  skl_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output skl_pkg::t_out_item o_out_data
);
    import skl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [2:0]          r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [KEY_BITS-1:0] w_key  [CAPACITY];
    logic [CAPACITY-1:0] w_flag;
    t_cell_ctl           w_ctl  [CAPACITY];

    logic                w_adv;
    logic                w_found;
    logic [IDX_W-1:0]    w_hit_idx;
    logic [IDX_W-1:0]    n_pos;
    t_status             n_status;
    logic                n_ins;
    logic                n_del;
    logic                w_full;

    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_adv      = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        w_found   = 1'b0;
        w_hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (w_flag[i]) begin
                w_found   = 1'b1;
                w_hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_status = ST_OK;
        n_pos    = '0;
        n_ins    = 1'b0;
        n_del    = 1'b0;
        case (r_op)
            OP_SORTED: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_ins = 1'b1;
                    n_pos = w_found ? w_hit_idx : r_count[IDX_W-1:0];
                end
            end
            OP_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_ins = 1'b1;
                end
            end
            OP_POP: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_del = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (w_found) begin
                    n_del = 1'b1;
                    n_pos = w_hit_idx;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_SEARCH: begin
                if (w_found) begin
                    n_pos = w_hit_idx;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        n_count = r_count;
        if (w_adv && n_ins) begin
            n_count = r_count + 1'b1;
        end else if (w_adv && n_del) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_ctl[i].cmp_en   = (r_state == S_CMP);
            w_ctl[i].occupied = (CNT_W'(i) < r_count);
            if (r_op == OP_SORTED) begin
                w_ctl[i].mode = (i == 0) ? CMP_GT : CMP_GE;
            end else begin
                w_ctl[i].mode = CMP_EQ;
            end
            w_ctl[i].op = CELL_HOLD;
            if (w_adv && n_ins) begin
                if (IDX_W'(i) == n_pos) begin
                    w_ctl[i].op = CELL_LOAD;
                end else if (IDX_W'(i) > n_pos) begin
                    w_ctl[i].op = CELL_LEFT;
                end
            end else if (w_adv && n_del) begin
                if (IDX_W'(i) >= n_pos && i < CAPACITY - 1) begin
                    w_ctl[i].op = CELL_RIGHT;
                end
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        skl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_key   (r_key),
            .i_left  ((g == 0) ? r_key : w_key[(g == 0) ? 0 : g - 1]),
            .i_right ((g == CAPACITY - 1) ? w_key[g] : w_key[(g == CAPACITY - 1) ? g : g + 1]),
            .o_key   (w_key[g]),
            .o_flag  (w_flag[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CMP;
            S_CMP:   n_state = S_APPLY;
            S_APPLY: if (w_adv) n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op  <= i_in_data.operation;
            r_key <= i_in_data.key;
        end
        if (w_adv) begin
            r_out.status      <= n_status;
            r_out.position    <= 4'(n_pos);
            r_out.entry_count <= 5'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1)
                  || (r_count == $past(r_count) - 1'b1))
        else $error("count moved by more than one");

    a_refused_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_status != ST_OK) |=> $stable(r_count))
        else $error("refused operation changed the count");

    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CMP) && !o_in_ready)
        else $error("accepted transaction did not start compare");

endmodule

`default_nettype wire
